@@ sv/tile_row_copy_run_generator_unit_macros.svh @@
// Assertion macros for the tile row copy run generator.
`ifndef TILE_ROW_COPY_RUN_GENERATOR_UNIT_MACROS_SVH
`define TILE_ROW_COPY_RUN_GENERATOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define TRCG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("trcg: same-cycle check failed");
// next-cycle implication
`define TRCG_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("trcg: next-cycle check failed");
`else
`define TRCG_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TRCG_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ sv/trcg_pkg.sv @@
// Shared types and constants of the tile row copy run generator.
package trcg_pkg;

  // field widths
  localparam int CFG_W = 15;
  localparam int IDX_W = 10;
  localparam int PG_W  = 7;
  localparam int ROW_W = 8;
  localparam int SRC_W = 28;
  localparam int DST_W = 24;
  localparam int LEN_W = 8;
  // clamped level size; the front end keeps it within MAX_LEVEL_SIZE
  localparam int LVL_W = 17;

  localparam logic [CFG_W-1:0] LEVEL_RESET = CFG_W'(128);

  // register indexes (byte address bit 2)
  localparam logic [0:0] REG_LEVEL_WIDTH  = 1'b0;
  localparam logic [0:0] REG_LEVEL_HEIGHT = 1'b1;

  localparam int MAX_RUNS = 3;

  // front/back queue
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  // one classified row, ready for run emission
  typedef struct packed {
    logic [SRC_W-1:0] src_base;
    logic [DST_W-1:0] dst_row;
    logic [LVL_W-1:0] level_w;
    logic [LVL_W-1:0] sx0;
  } trcg_entry_t;

  typedef struct packed {
    logic valid;
    logic full;
  } trcg_qstat_t;

endpackage

@@ sv/trcg_front.sv @@
// Front end: accepts a row beat, wraps coordinates, splits the tile slot, builds the entry.
module trcg_front import trcg_pkg::*; #(
  parameter int PAGE_SIZE      = 128,
  parameter int PAGE_BORDER    = 4,
  parameter int TILE_SIZE      = 136,
  parameter int TILES_PER_SIDE = 30,
  parameter int ATLAS_SIZE     = 4096,
  parameter int MAX_LEVEL_SIZE = 16384
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [IDX_W-1:0]  in_tile_index,
  input  logic [PG_W-1:0]   in_page_x,
  input  logic [PG_W-1:0]   in_page_y,
  input  logic [ROW_W-1:0]  in_tile_row,
  input  logic [CFG_W-1:0]  level_width,
  input  logic [CFG_W-1:0]  level_height,
  input  trcg_qstat_t       q_stat,
  output logic              q_push,
  output trcg_entry_t       q_entry
);

  // nonnegative source coordinate bound and divider depth
  localparam int VMAX = 128 * PAGE_SIZE + TILE_SIZE;
  localparam int VW   = $clog2(VMAX);
  localparam int NS   = VW;
  localparam int TYW  = $clog2(TILES_PER_SIDE + 1);
  localparam int RIW  = $clog2(TILES_PER_SIDE * TILE_SIZE + 1);
  localparam int PW   = RIW + $clog2(ATLAS_SIZE + 1) + 1;
  // tile slot row by reciprocal multiply, exact for any 10-bit index
  localparam int RSH   = 20;
  localparam int RCW   = RSH + 1;
  localparam int RECIP = (2**RSH + TILES_PER_SIDE - 1) / TILES_PER_SIDE;

  typedef struct packed {
    logic [LVL_W-1:0] w;
    logic [LVL_W-1:0] h;
    logic [ROW_W-1:0] row;
    logic             negx;
    logic             negy;
    logic [LVL_W-1:0] sxl;
    logic [LVL_W-1:0] syl;
    logic [LVL_W-1:0] rx;
    logic [LVL_W-1:0] ry;
    logic [NS-1:0]    dx;
    logic [NS-1:0]    dy;
    logic [IDX_W-1:0] tidx;
    logic [TYW-1:0]   ty;
  } dstage_t;

  typedef struct packed {
    logic [LVL_W-1:0] sx0;
    logic [LVL_W-1:0] sy;
    logic [LVL_W-1:0] w;
    logic [RIW-1:0]   row_idx;
    logic [RIW-1:0]   tcol;
  } post_t;

  // one restoring division step on both coordinate lanes
  function automatic dstage_t div_step(dstage_t s);
    dstage_t          o;
    logic [LVL_W:0]   r2x;
    logic [LVL_W:0]   r2y;
    o   = s;
    r2x = {s.rx, s.dx[NS-1]};
    r2y = {s.ry, s.dy[NS-1]};
    o.rx = (r2x >= {1'b0, s.w}) ? LVL_W'(r2x - {1'b0, s.w}) : r2x[LVL_W-1:0];
    o.ry = (r2y >= {1'b0, s.h}) ? LVL_W'(r2y - {1'b0, s.h}) : r2y[LVL_W-1:0];
    o.dx = s.dx << 1;
    o.dy = s.dy << 1;
    return o;
  endfunction

  dstage_t          st_r  [0:NS];
  logic             vld_r [0:NS];
  dstage_t          st_nxt[0:NS];
  post_t            p0_r;
  post_t            p0_nxt;
  logic             p0_vld_r;
  trcg_entry_t      p1_r;
  trcg_entry_t      p1_nxt;
  logic             p1_vld_r;
  logic             adv;
  logic             in_ok;
  logic [LVL_W-1:0] w_raw;
  logic [LVL_W-1:0] h_raw;
  logic [LVL_W-1:0] w_cl;
  logic [LVL_W-1:0] h_cl;
  logic [VW:0]      vx;
  logic [VW:0]      vy;
  logic [IDX_W+RCW-1:0] tprod;
  logic [IDX_W-1:0] tslot_x;
  logic [2*LVL_W-1:0] prod;
  logic [PW-1:0]    dst_full;

  // whole pipe holds while the last stage waits on a full queue
  assign adv    = !(p1_vld_r && q_stat.full);
  assign busy   = !adv;
  assign q_push = p1_vld_r && !q_stat.full;
  assign q_entry = p1_r;

  // slots beyond the atlas and rows beyond the tile produce nothing
  assign in_ok = (32'(in_tile_index) < TILES_PER_SIDE * TILES_PER_SIDE) &&
                 (32'(in_tile_row) < TILE_SIZE);

  // level size clamp
  always_comb begin
    w_raw = LVL_W'(level_width);
    h_raw = LVL_W'(level_height);
    if (w_raw < LVL_W'(PAGE_SIZE)) begin
      w_cl = LVL_W'(PAGE_SIZE);
    end else if (w_raw > LVL_W'(MAX_LEVEL_SIZE)) begin
      w_cl = LVL_W'(MAX_LEVEL_SIZE);
    end else begin
      w_cl = w_raw;
    end
    if (h_raw < LVL_W'(PAGE_SIZE)) begin
      h_cl = LVL_W'(PAGE_SIZE);
    end else if (h_raw > LVL_W'(MAX_LEVEL_SIZE)) begin
      h_cl = LVL_W'(MAX_LEVEL_SIZE);
    end else begin
      h_cl = h_raw;
    end
  end

  // stage 0: page origin minus border (plus tile row on y), sign split, tile slot row
  always_comb begin
    vx = (VW+1)'(in_page_x) * (VW+1)'(PAGE_SIZE) - (VW+1)'(PAGE_BORDER);
    vy = (VW+1)'(in_page_y) * (VW+1)'(PAGE_SIZE) - (VW+1)'(PAGE_BORDER)
         + (VW+1)'(in_tile_row);
    tprod = (IDX_W+RCW)'(in_tile_index) * (IDX_W+RCW)'(RECIP);
    st_nxt[0].w    = w_cl;
    st_nxt[0].h    = h_cl;
    st_nxt[0].row  = in_tile_row;
    st_nxt[0].negx = vx[VW];
    st_nxt[0].negy = vy[VW];
    st_nxt[0].sxl  = LVL_W'({{LVL_W{vx[VW]}}, vx});
    st_nxt[0].syl  = LVL_W'({{LVL_W{vy[VW]}}, vy});
    st_nxt[0].rx   = '0;
    st_nxt[0].ry   = '0;
    st_nxt[0].dx   = vx[VW] ? '0 : NS'(vx[VW-1:0]);
    st_nxt[0].dy   = vy[VW] ? '0 : NS'(vy[VW-1:0]);
    st_nxt[0].tidx = in_tile_index;
    st_nxt[0].ty   = TYW'(tprod >> RSH);
    for (int k = 1; k <= NS; k++) begin
      st_nxt[k] = div_step(st_r[k-1]);
    end
  end

  // post 0: negative coordinates wrap by one extent; tile slot row and column
  always_comb begin
    tslot_x = st_r[NS].tidx - IDX_W'(st_r[NS].ty) * IDX_W'(TILES_PER_SIDE);
    p0_nxt.sx0 = st_r[NS].negx ? LVL_W'(st_r[NS].w + st_r[NS].sxl) : st_r[NS].rx;
    p0_nxt.sy  = st_r[NS].negy ? LVL_W'(st_r[NS].h + st_r[NS].syl) : st_r[NS].ry;
    p0_nxt.w   = st_r[NS].w;
    p0_nxt.row_idx = RIW'(st_r[NS].ty) * RIW'(TILE_SIZE)
                     + RIW'(st_r[NS].row);
    p0_nxt.tcol    = RIW'(tslot_x) * RIW'(TILE_SIZE);
  end

  // post 1: source row base and atlas row offset
  always_comb begin
    prod     = (2*LVL_W)'(p0_r.sy) * (2*LVL_W)'(p0_r.w);
    dst_full = PW'(p0_r.row_idx) * PW'(ATLAS_SIZE) + PW'(p0_r.tcol);
    p1_nxt.src_base = SRC_W'(prod);
    p1_nxt.dst_row  = DST_W'(dst_full);
    p1_nxt.level_w  = p0_r.w;
    p1_nxt.sx0      = p0_r.sx0;
  end

  // pipeline registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= NS; k++) begin
        vld_r[k] <= 1'b0;
      end
      p0_vld_r <= 1'b0;
      p1_vld_r <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= start && in_ok;
      st_r[0]  <= st_nxt[0];
      for (int k = 1; k <= NS; k++) begin
        vld_r[k] <= vld_r[k-1];
        st_r[k]  <= st_nxt[k];
      end
      p0_vld_r <= vld_r[NS];
      p0_r     <= p0_nxt;
      p1_vld_r <= p0_vld_r;
      p1_r     <= p1_nxt;
    end
  end

endmodule

@@ sv/trcg_queue.sv @@
// Short queue of classified rows between front and back.
module trcg_queue import trcg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  trcg_entry_t push_entry,
  input  logic        pop,
  output trcg_qstat_t stat,
  output trcg_entry_t head
);

  trcg_entry_t       mem_r [0:QDEPTH-1];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push;
  logic              do_pop;

  assign stat.valid = (count_r != '0);
  assign stat.full  = (count_r == QCNT_W'(QDEPTH));
  assign head       = mem_r[rd_ptr_r];
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && stat.valid;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

@@ sv/trcg_back.sv @@
// Back end: walks one queued row and emits one run beat per cycle.
module trcg_back import trcg_pkg::*; #(
  parameter int TILE_SIZE = 136
) (
  input  logic             clk,
  input  logic             rst_n,
  input  trcg_qstat_t      q_stat,
  input  trcg_entry_t      q_head,
  output logic             q_pop,
  output logic             out_strobe,
  output logic [SRC_W-1:0] out_src_texel_offset,
  output logic [DST_W-1:0] out_dst_texel_offset,
  output logic [LEN_W-1:0] out_run_length,
  output logic             out_last_run
);

  localparam int XW = $clog2(TILE_SIZE + 1);

  logic             active_r;
  trcg_entry_t      ent_r;
  logic [XW-1:0]    x_r;
  logic [LVL_W-1:0] sx_r;
  logic [1:0]       n_r;
  logic             strobe_r;
  logic [SRC_W-1:0] src_r;
  logic [DST_W-1:0] dst_r;
  logic [LEN_W-1:0] len_r;
  logic             last_r;

  logic [XW-1:0]    left;
  logic [LVL_W-1:0] room;
  logic [XW-1:0]    run;
  logic [XW:0]      xsum;
  logic             last;

  // run length: rest of the tile row or up to the wrap point
  always_comb begin
    left = XW'(TILE_SIZE) - x_r;
    room = ent_r.level_w - sx_r;
    run  = (LVL_W'(left) < room) ? left : room[XW-1:0];
    xsum = (XW+1)'(x_r) + (XW+1)'(run);
    last = (xsum >= (XW+1)'(TILE_SIZE)) || (n_r == 2'(MAX_RUNS - 1));
  end

  assign q_pop = q_stat.valid && (!active_r || last);

  // row walker and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= active_r;
      if (q_pop) begin
        active_r <= 1'b1;
        ent_r    <= q_head;
        x_r      <= '0;
        sx_r     <= q_head.sx0;
        n_r      <= '0;
      end else if (active_r && last) begin
        active_r <= 1'b0;
      end else if (active_r) begin
        x_r  <= xsum[XW-1:0];
        sx_r <= '0;
        n_r  <= n_r + 1'b1;
      end
    end
  end

  // payload of the run beat
  always_ff @(posedge clk) begin
    src_r  <= ent_r.src_base + SRC_W'(sx_r);
    dst_r  <= ent_r.dst_row + DST_W'(x_r);
    len_r  <= LEN_W'(run);
    last_r <= last;
  end

  assign out_strobe           = strobe_r;
  assign out_src_texel_offset = src_r;
  assign out_dst_texel_offset = dst_r;
  assign out_run_length       = len_r;
  assign out_last_run         = last_r;

endmodule

@@ sv/tile_row_copy_run_generator_unit.sv @@
// Top level of the tile row copy run generator: register port, front, queue, back.
// A row beat is taken whenever start is high and busy is low; with the default
// parameters it passes one divider stage per bit of the 15-bit source coordinate,
// two address stages, the queue, the row load into the run emitter and the
// output register before its first run beat is on out_*.
// The run emitter then produces one run beat per cycle, one to three per row,
// and that emitter sets the sustained rate: three run beats per row when rows
// wrap twice, one when they do not wrap. Rows with a tile slot or tile row out
// of range are dropped and produce no run beat. Run beats appear on out_* for
// exactly one cycle with out_strobe high and cannot be held off; busy rises only
// while the two-entry queue is full and a finished row waits.
`include "tile_row_copy_run_generator_unit_macros.svh"
module tile_row_copy_run_generator_unit import trcg_pkg::*; #(
  parameter int PAGE_SIZE      = 128,
  parameter int PAGE_BORDER    = 4,
  parameter int TILE_SIZE      = 136,
  parameter int TILES_PER_SIDE = 30,
  parameter int ATLAS_SIZE     = 4096,
  parameter int MAX_LEVEL_SIZE = 16384
) (
  input  logic             clk,
  input  logic             rst_n,
  // register port
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // row beats
  input  logic             start,
  output logic             busy,
  input  logic [IDX_W-1:0] in_tile_index,
  input  logic [PG_W-1:0]  in_page_x,
  input  logic [PG_W-1:0]  in_page_y,
  input  logic [ROW_W-1:0] in_tile_row,
  // run beats
  output logic             out_strobe,
  output logic [SRC_W-1:0] out_src_texel_offset,
  output logic [DST_W-1:0] out_dst_texel_offset,
  output logic [LEN_W-1:0] out_run_length,
  output logic             out_last_run
);

  logic [CFG_W-1:0] level_width_r;
  logic [CFG_W-1:0] level_height_r;
  logic             cfg_we;
  logic             q_push;
  logic             q_pop;
  trcg_entry_t      q_in;
  trcg_entry_t      q_head;
  trcg_qstat_t      q_stat;

  // register writes and reads
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_width_r  <= LEVEL_RESET;
      level_height_r <= LEVEL_RESET;
    end else if (cfg_we) begin
      case (paddr[2])
        REG_LEVEL_WIDTH:  level_width_r  <= pwdata[CFG_W-1:0];
        REG_LEVEL_HEIGHT: level_height_r <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_LEVEL_WIDTH:  prdata = 32'(level_width_r);
      REG_LEVEL_HEIGHT: prdata = 32'(level_height_r);
      default:          prdata = '0;
    endcase
  end

  trcg_front #(
    .PAGE_SIZE      (PAGE_SIZE),
    .PAGE_BORDER    (PAGE_BORDER),
    .TILE_SIZE      (TILE_SIZE),
    .TILES_PER_SIDE (TILES_PER_SIDE),
    .ATLAS_SIZE     (ATLAS_SIZE),
    .MAX_LEVEL_SIZE (MAX_LEVEL_SIZE)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_tile_index (in_tile_index),
    .in_page_x     (in_page_x),
    .in_page_y     (in_page_y),
    .in_tile_row   (in_tile_row),
    .level_width   (level_width_r),
    .level_height  (level_height_r),
    .q_stat        (q_stat),
    .q_push        (q_push),
    .q_entry       (q_in)
  );

  trcg_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .pop        (q_pop),
    .stat       (q_stat),
    .head       (q_head)
  );

  trcg_back #(
    .TILE_SIZE (TILE_SIZE)
  ) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_stat               (q_stat),
    .q_head               (q_head),
    .q_pop                (q_pop),
    .out_strobe           (out_strobe),
    .out_src_texel_offset (out_src_texel_offset),
    .out_dst_texel_offset (out_dst_texel_offset),
    .out_run_length       (out_run_length),
    .out_last_run         (out_last_run)
  );

  // front stalls only behind a full queue
  `TRCG_ASSERT_IMP(a_busy_needs_full, clk, rst_n, busy, q_stat.full)
  // runs of one row leave back to back
  `TRCG_ASSERT_NXT(a_runs_contiguous, clk, rst_n, out_strobe && !out_last_run, out_strobe)
  // back never takes from an empty queue
  `TRCG_ASSERT_IMP(a_pop_nonempty, clk, rst_n, q_pop, q_stat.valid)

endmodule
